>>> src/html_entity_decoder_macros.svh
// Assertion macros used by the checker of the entity decoder.
`ifndef HTML_ENTITY_DECODER_MACROS_SVH
`define HTML_ENTITY_DECODER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HED_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define HED_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/hed_pkg.sv
// Types and constants shared by the entity decoder modules.
package hed_pkg;

    localparam logic [7:0] AMP_CHAR     = 8'h26;
    localparam logic [7:0] SEMI_CHAR    = 8'h3B;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    localparam int RESULT_LIMIT = 8;
    localparam int NW           = $clog2(RESULT_LIMIT + 1);

    localparam int Q_DEPTH = 2;
    localparam int QPW     = $clog2(Q_DEPTH);
    localparam int QCW     = $clog2(Q_DEPTH + 1);

    localparam int NUM_ENT     = 5;
    localparam int ENT_MAX_LEN = 4;

    localparam logic [7:0] ENT_TEXT [NUM_ENT][ENT_MAX_LEN] = '{
        '{8'h71, 8'h75, 8'h6F, 8'h74},
        '{8'h61, 8'h70, 8'h6F, 8'h73},
        '{8'h6C, 8'h74, 8'h00, 8'h00},
        '{8'h67, 8'h74, 8'h00, 8'h00},
        '{8'h61, 8'h6D, 8'h70, 8'h00}
    };
    localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd4, 3'd4, 3'd2, 3'd2, 3'd3};
    localparam logic [7:0] ENT_REPL [NUM_ENT] = '{8'h22, 8'h27, 8'h3C, 8'h3E, 8'h26};

    typedef enum logic [1:0] {
        CL_OTHER = 2'd0,
        CL_AMP   = 2'd1,
        CL_SEMI  = 2'd2,
        CL_NL    = 2'd3
    } t_class;

    typedef struct packed {
        t_class     cls;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_FLUSH  = 3'b010,
        ST_RESCAN = 3'b100
    } t_bstate;

endpackage

>>> src/hed_front.sv
// Input stage that accepts text bytes and tags each with its character class.
module hed_front import hed_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_ready
);

    logic   r_v;
    t_cmd   r_cmd;
    t_class cls;
    logic   accept;

    always_comb begin
        unique case (i_in_byte)
            AMP_CHAR:     cls = CL_AMP;
            SEMI_CHAR:    cls = CL_SEMI;
            NEWLINE_CHAR: cls = CL_NL;
            default:      cls = CL_OTHER;
        endcase
    end

    assign o_stall     = r_v && !i_cmd_ready;
    assign accept      = i_valid && !o_stall;
    assign o_cmd_valid = r_v;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (i_cmd_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.cls  <= cls;
            r_cmd.data <= i_in_byte;
        end
    end

endmodule

>>> src/hed_queue.sv
// Short command queue between the classifying front and the decoding back.
module hed_queue import hed_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cmd i_push_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop_cmd,
    input  logic i_pop
);

    t_cmd           r_mem [Q_DEPTH];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QCW-1:0] r_fill;
    logic           push;
    logic           pop;

    assign o_push_ready = r_fill != QCW'(Q_DEPTH);
    assign o_pop_valid  = r_fill != '0;
    assign o_pop_cmd    = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QPW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

endmodule

>>> src/hed_back.sv
// Entity sequencer that holds the name, matches it and emits the decoded bytes.
module hed_back import hed_pkg::*; #(
    parameter int MAX_NAME_LEN = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    localparam int BW = $clog2(MAX_NAME_LEN);
    localparam int CW = $clog2(MAX_NAME_LEN + 1);
    localparam int IW = $clog2(MAX_NAME_LEN + 2);

    t_bstate       r_state, n_state;
    logic          r_open, n_open;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_buf [MAX_NAME_LEN];
    logic [7:0]    r_tail, n_tail;
    logic [IW-1:0] r_pos, n_pos;
    logic [IW-1:0] r_stop, n_stop;
    logic [NW-1:0] r_nout, n_nout;
    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic          r_olast;

    logic          out_free;
    logic          emit;
    logic [7:0]    e_byte;
    logic          e_last;
    logic          wr_en;
    logic [7:0]    wr_data;
    logic [IW-1:0] pos_m1;
    logic [IW-1:0] lim;
    logic [7:0]    seq_byte;
    logic          hit;
    logic [7:0]    hit_repl;
    logic [IW-1:0] first_amp;
    logic          cap_reached;
    logic          cap_next;
    logic          ent_ok;

    assign out_free    = !r_ovalid || !i_stall;
    assign cap_reached = r_nout == NW'(RESULT_LIMIT);
    assign cap_next    = r_nout == NW'(RESULT_LIMIT - 1);
    assign pos_m1      = r_pos - 1'b1;
    assign lim         = (r_state == ST_RESCAN) ? IW'(MAX_NAME_LEN) : IW'(r_cnt);
    assign seq_byte    = (r_pos <= lim) ? r_buf[pos_m1[BW-1:0]] : r_tail;

    always_comb begin
        hit      = 1'b0;
        hit_repl = AMP_CHAR;
        for (int k = 0; k < NUM_ENT; k++) begin
            ent_ok = r_cnt == CW'(ENT_LEN[k]);
            for (int i = 0; i < ENT_MAX_LEN; i++) begin
                if (i < int'(ENT_LEN[k]) && r_buf[i] != ENT_TEXT[k][i]) begin
                    ent_ok = 1'b0;
                end
            end
            if (ent_ok) begin
                hit      = 1'b1;
                hit_repl = ENT_REPL[k];
            end
        end
    end

    always_comb begin
        first_amp = IW'(MAX_NAME_LEN + 1);
        if (i_cmd.data == AMP_CHAR) begin
            first_amp = IW'(MAX_NAME_LEN);
        end
        for (int k = MAX_NAME_LEN - 1; k >= 0; k--) begin
            if (r_buf[k] == AMP_CHAR) begin
                first_amp = IW'(k);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_open  = r_open;
        n_cnt   = r_cnt;
        n_tail  = r_tail;
        n_pos   = r_pos;
        n_stop  = r_stop;
        n_nout  = r_nout;
        o_pop   = 1'b0;
        emit    = 1'b0;
        e_byte  = seq_byte;
        e_last  = 1'b0;
        wr_en   = 1'b0;
        wr_data = i_cmd.data;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (!r_open) begin
                        if (i_cmd.cls == CL_AMP) begin
                            o_pop  = 1'b1;
                            n_open = 1'b1;
                            n_cnt  = '0;
                        end else if (out_free) begin
                            o_pop  = 1'b1;
                            emit   = 1'b1;
                            e_byte = i_cmd.data;
                            e_last = 1'b1;
                        end
                    end else begin
                        unique case (i_cmd.cls) inside
                            CL_NL: begin
                                o_pop   = 1'b1;
                                n_tail  = i_cmd.data;
                                n_pos   = '0;
                                n_nout  = '0;
                                n_state = ST_FLUSH;
                            end
                            CL_SEMI: begin
                                if (hit) begin
                                    if (out_free) begin
                                        o_pop  = 1'b1;
                                        emit   = 1'b1;
                                        e_byte = hit_repl;
                                        e_last = 1'b1;
                                        n_open = 1'b0;
                                        n_cnt  = '0;
                                    end
                                end else begin
                                    o_pop   = 1'b1;
                                    n_tail  = SEMI_CHAR;
                                    n_pos   = '0;
                                    n_nout  = '0;
                                    n_state = ST_FLUSH;
                                end
                            end
                            CL_AMP, CL_OTHER: begin
                                o_pop = 1'b1;
                                if (r_cnt < CW'(MAX_NAME_LEN)) begin
                                    wr_en = 1'b1;
                                    n_cnt = r_cnt + 1'b1;
                                end else begin
                                    n_tail  = i_cmd.data;
                                    n_stop  = first_amp;
                                    n_pos   = '0;
                                    n_nout  = '0;
                                    n_open  = 1'b0;
                                    n_cnt   = '0;
                                    n_state = ST_RESCAN;
                                end
                            end
                            default: begin
                                o_pop = 1'b0;
                            end
                        endcase
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_byte = (r_pos == '0) ? AMP_CHAR : seq_byte;
                    e_last = (r_pos == IW'(r_cnt) + 1'b1) || cap_next;
                    n_nout = r_nout + 1'b1;
                    n_pos  = r_pos + 1'b1;
                    if (e_last) begin
                        n_open  = 1'b0;
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_RESCAN: begin
                if (r_pos == '0) begin
                    if (out_free) begin
                        emit   = 1'b1;
                        e_byte = AMP_CHAR;
                        e_last = r_stop == '0;
                        n_nout = r_nout + 1'b1;
                        n_pos  = r_pos + 1'b1;
                    end
                end else begin
                    wr_data = seq_byte;
                    if (r_open) begin
                        if (r_cnt < CW'(MAX_NAME_LEN)) begin
                            wr_en = 1'b1;
                            n_cnt = r_cnt + 1'b1;
                        end
                        n_pos = r_pos + 1'b1;
                    end else if (seq_byte == AMP_CHAR) begin
                        n_open = 1'b1;
                        n_cnt  = '0;
                        n_pos  = r_pos + 1'b1;
                    end else if (cap_reached) begin
                        n_pos = r_pos + 1'b1;
                    end else if (out_free) begin
                        emit   = 1'b1;
                        e_last = (r_pos == r_stop) || cap_next;
                        n_nout = r_nout + 1'b1;
                        n_pos  = r_pos + 1'b1;
                    end
                    if (n_pos != r_pos && r_pos == IW'(MAX_NAME_LEN + 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_open   <= 1'b0;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_nout   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            r_nout  <= n_nout;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail <= n_tail;
        r_stop <= n_stop;
        if (wr_en) begin
            r_buf[r_cnt[BW-1:0]] <= wr_data;
        end
        if (emit) begin
            r_obyte <= e_byte;
            r_olast <= e_last;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_out_byte    = r_obyte;
    assign o_last_of_run = r_olast;

endmodule

>>> src/html_entity_decoder.sv
// Streaming decoder for the five XML entities. Plain bytes, held name bytes and
// matched entities flow through the sequencer at one item per cycle while the output
// is not stalled, behind a registered input stage and a two-entry command queue.
// Flushing an unmatched or newline-cut name of N bytes emits the ampersand, the N name
// bytes and the cutting byte; a name that runs past MAX_NAME_LEN bytes is replayed from
// its ampersand, one name byte per cycle unless the output stalls. An output register
// holds a stalled result while input bytes still fill the queue and name bytes are taken.
module html_entity_decoder import hed_pkg::*; #(
    parameter int MAX_NAME_LEN = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    logic f_valid;
    t_cmd f_cmd;
    logic f_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    hed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .o_cmd_valid (f_valid),
        .o_cmd       (f_cmd),
        .i_cmd_ready (f_ready)
    );

    hed_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push_cmd   (f_cmd),
        .o_push_ready (f_ready),
        .o_pop_valid  (q_valid),
        .o_pop_cmd    (q_cmd),
        .i_pop        (q_pop)
    );

    hed_back #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

>>> src/hed_checker.sv
// Port-level checker for the entity decoder and its bind to the top level.
`include "html_entity_decoder_macros.svh"

module hed_checker import hed_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_run
);

    logic [3:0]    r_pend;
    logic [NW-1:0] r_run;
    logic          in_acc;
    logic          out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_run  <= '0;
        end else begin
            if (r_pend != 4'hF) begin
                r_pend <= r_pend + {3'b000, in_acc} - {3'b000, out_acc && o_last_of_run};
            end
            if (out_acc) begin
                r_run <= o_last_of_run ? '0 : r_run + 1'b1;
            end
        end
    end

    `HED_CHECK_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_out_byte) && $stable(o_last_of_run), "stalled output item changed")
    `HED_CHECK(a_out_has_source, o_valid, r_pend != '0, "output item without an accepted input item")
    `HED_CHECK_NEXT(a_run_continues, out_acc && !o_last_of_run, o_valid, "gap inside a run of output items")
    `HED_CHECK(a_run_limit, o_valid && r_run == NW'(RESULT_LIMIT - 1), o_last_of_run, "run of output items exceeds the limit")

endmodule

bind html_entity_decoder hed_checker u_hed_checker (.*);
